>>> src/byc_pkg.sv
// ----------------------------------------------------------------------------
// byc_pkg
// Shared types and constants of the BGR/YUV color space converter.
// ----------------------------------------------------------------------------
package byc_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned NumStages = 5;

  // Chroma offset (in pixel codes) and conversion coefficients (in units of 1e-5)
  localparam int ChromaOffset = 128;
  localparam int CoefYr       = 29900;
  localparam int CoefYg       = 58700;
  localparam int CoefYb       = 11400;
  localparam int CoefU        = 49200;
  localparam int CoefV        = 87700;
  localparam int CoefRv       = 113983;
  localparam int CoefGu       = 39465;
  localparam int CoefGv       = 58060;
  localparam int CoefBu       = 203211;
  localparam int CoefScale    = 100000;
  localparam int CoefRound    = 50000;

  typedef enum logic {
    DirBgrToYuv = 1'b0,
    DirYuvToBgr = 1'b1
  } dir_e;

  typedef struct packed {
    logic [PixW-1:0] first_channel;
    logic [PixW-1:0] second_channel;
    logic [PixW-1:0] third_channel;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] out_first;
    logic [PixW-1:0] out_second;
    logic [PixW-1:0] out_third;
  } pix_out_t;

endpackage

>>> src/bgr_yuv_color_space_converter_core.sv
// ----------------------------------------------------------------------------
// bgr_yuv_color_space_converter_core
// Per-pixel BGR <-> YUV (BT.601) converter in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_pixel_i) takes one pixel item,
//   output channel (out_valid_o/out_ready_i/out_pixel_o) gives one item back.
//   cfg_we_i writes cfg_wdata_i into the direction register: 0 converts B,G,R
//   to Y,U,V, 1 converts Y,U,V to B,G,R. Write it only while the block is
//   empty; each item takes the direction in force when it is accepted.
//   Five register stages (products, sums, differences, chroma multiply,
//   clamp), the first loaded at the accepting edge; out_valid_o rises once
//   the item is in the clamp stage's output register.
//   Throughput is one item per cycle while the receiver takes items.
//   Reset clears every valid bit and sets direction to BGR -> YUV.
//   When the receiver stalls, items advance into any empty stages behind the
//   output register; in_ready_o drops only once all five stages hold items.
//   Results are truncated toward zero and saturated to 0..255.
// ----------------------------------------------------------------------------
module bgr_yuv_color_space_converter_core #(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  byc_pkg::pix_in_t   in_pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output byc_pkg::pix_out_t  out_pixel_o
);
  import byc_pkg::*;

  dir_e                 dir_q;
  logic [NumStages-1:0] stage_en;
  logic [NumStages-1:0] stage_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirBgrToYuv;
    end else if (cfg_we_i) begin
      dir_q <= dir_e'(cfg_wdata_i);
    end
  end

  byc_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stage_en_o (stage_en),
    .stage_vld_o(stage_vld)
  );

  byc_datapath #(.CoefFracBits(COEF_FRAC_BITS)) u_datapath (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .dir_i      (dir_q),
    .in_pixel_i (in_pixel_i),
    .out_pixel_o(out_pixel_o)
  );

  // an empty output stage never back-pressures the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  // back-pressure only when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stage_vld == '1))
    else $error("input stalled with a bubble in the pipeline");

  // a stalled output item stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_pixel_o))
    else $error("stalled output item lost or changed");

endmodule

>>> src/byc_clamp.sv
// ----------------------------------------------------------------------------
// byc_clamp
// Drops the fraction bits of a signed fixed-point value and saturates to a byte.
// ----------------------------------------------------------------------------
module byc_clamp #(
  parameter int unsigned Width = 27,
  parameter int unsigned Shift = 16
) (
  input  logic signed [Width-1:0]     value_i,
  output logic [byc_pkg::PixW-1:0]    byte_o
);
  import byc_pkg::*;

  always_comb begin
    priority if (value_i[Width-1] || (value_i == '0)) begin
      byte_o = '0;
    end else if (|value_i[Width-2:Shift+PixW]) begin
      byte_o = '1;
    end else begin
      byte_o = value_i[Shift+PixW-1:Shift];
    end
  end

endmodule

>>> src/byc_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// byc_pipe_ctrl
// Valid bits and per-stage load enables; empty stages close up under a stall.
// ----------------------------------------------------------------------------
module byc_pipe_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [byc_pkg::NumStages-1:0] stage_en_o,
  output logic [byc_pkg::NumStages-1:0] stage_vld_o
);
  import byc_pkg::*;

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] en;

  // a stage may load when it is empty or its item moves on
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];
  assign stage_en_o  = en;
  assign stage_vld_o = vld_q;

endmodule

>>> src/byc_datapath.sv
// ----------------------------------------------------------------------------
// byc_datapath
// Five-stage fixed-point datapath: products, sums, differences, chroma
// scaling, clamp into the output register.
// ----------------------------------------------------------------------------
module byc_datapath #(
  parameter int unsigned CoefFracBits = 16
) (
  input  logic                          clk_i,
  input  logic [byc_pkg::NumStages-1:0] stage_en_i,
  input  byc_pkg::dir_e                 dir_i,
  input  byc_pkg::pix_in_t              in_pixel_i,
  output byc_pkg::pix_out_t             out_pixel_o
);
  import byc_pkg::*;

  localparam int unsigned F  = CoefFracBits;
  localparam int unsigned W1 = F + 11;      // one-scale values, sign included
  localparam int unsigned W2 = 2 * F + 11;  // two-scale chroma values

  localparam logic signed [W1-1:0] KYr =
    W1'(((longint'(CoefYr) << F) + longint'(CoefRound)) / longint'(CoefScale));
  localparam logic signed [W1-1:0] KYg =
    W1'(((longint'(CoefYg) << F) + longint'(CoefRound)) / longint'(CoefScale));
  localparam logic signed [W1-1:0] KYb =
    W1'(((longint'(CoefYb) << F) + longint'(CoefRound)) / longint'(CoefScale));
  localparam logic signed [W1-1:0] KRv =
    W1'(((longint'(CoefRv) << F) + longint'(CoefRound)) / longint'(CoefScale));
  localparam logic signed [W1-1:0] KGu =
    W1'(((longint'(CoefGu) << F) + longint'(CoefRound)) / longint'(CoefScale));
  localparam logic signed [W1-1:0] KGv =
    W1'(((longint'(CoefGv) << F) + longint'(CoefRound)) / longint'(CoefScale));
  localparam logic signed [W1-1:0] KBu =
    W1'(((longint'(CoefBu) << F) + longint'(CoefRound)) / longint'(CoefScale));
  localparam logic signed [W2-1:0] KU =
    W2'(((longint'(CoefU) << F) + longint'(CoefRound)) / longint'(CoefScale));
  localparam logic signed [W2-1:0] KV =
    W2'(((longint'(CoefV) << F) + longint'(CoefRound)) / longint'(CoefScale));
  localparam logic signed [W2-1:0] OffUv = W2'(ChromaOffset) << (2 * F);
  localparam logic signed [W1-1:0] OffIn = W1'(ChromaOffset);

  // stage 1: coefficient products
  logic signed [W1-1:0] c0_s, c1_s, c2_s, u_s, v_s;
  logic signed [W1-1:0] p0_d, p1_d, p2_d, p3_d;
  logic signed [W1-1:0] p0_q, p1_q, p2_q, p3_q;
  dir_e                 dir1_q;
  logic [PixW-1:0]      c0_1_q, c2_1_q;

  always_comb begin
    c0_s = W1'(in_pixel_i.first_channel);
    c1_s = W1'(in_pixel_i.second_channel);
    c2_s = W1'(in_pixel_i.third_channel);
    u_s  = c1_s - OffIn;
    v_s  = c2_s - OffIn;
    if (dir_i == DirYuvToBgr) begin
      p0_d = KBu * u_s;
      p1_d = KGu * u_s;
      p2_d = KGv * v_s;
    end else begin
      p0_d = KYr * c2_s;
      p1_d = KYg * c1_s;
      p2_d = KYb * c0_s;
    end
    p3_d = KRv * v_s;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      dir1_q <= dir_i;
      c0_1_q <= in_pixel_i.first_channel;
      c2_1_q <= in_pixel_i.third_channel;
      p0_q   <= p0_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      p3_q   <= p3_d;
    end
  end

  // stage 2: luma sum (forward) or the three reverse sums
  logic signed [W1-1:0] base1;
  logic signed [W1-1:0] a0_d, a1_d, a2_d;
  logic signed [W1-1:0] a0_q, a1_q, a2_q;
  dir_e                 dir2_q;
  logic [PixW-1:0]      c0_2_q, c2_2_q;

  always_comb begin
    base1 = W1'(c0_1_q) << F;
    a0_d  = (dir1_q == DirYuvToBgr) ? (base1 + p0_q) : (p0_q + p1_q + p2_q);
    a1_d  = base1 - p1_q - p2_q;
    a2_d  = base1 + p3_q;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      dir2_q <= dir1_q;
      c0_2_q <= c0_1_q;
      c2_2_q <= c2_1_q;
      a0_q   <= a0_d;
      a1_q   <= a1_d;
      a2_q   <= a2_d;
    end
  end

  // stage 3: B - Y and R - Y at full precision (forward); reverse sums pass through
  logic signed [W1-1:0] b1_d, b2_d;
  logic signed [W1-1:0] b0_q, b1_q, b2_q;
  dir_e                 dir3_q;

  always_comb begin
    if (dir2_q == DirYuvToBgr) begin
      b1_d = a1_q;
      b2_d = a2_q;
    end else begin
      b1_d = (W1'(c0_2_q) << F) - a0_q;
      b2_d = (W1'(c2_2_q) << F) - a0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      dir3_q <= dir2_q;
      b0_q   <= a0_q;
      b1_q   <= b1_d;
      b2_q   <= b2_d;
    end
  end

  // stage 4: chroma scaling (forward); reverse values pass through
  logic signed [W2-1:0] e1_d, e2_d;
  logic signed [W2-1:0] e1_q, e2_q;
  logic signed [W1-1:0] e0_q;
  dir_e                 dir4_q;

  always_comb begin
    if (dir3_q == DirYuvToBgr) begin
      e1_d = W2'(b1_q);
      e2_d = W2'(b2_q);
    end else begin
      e1_d = KU * W2'(b1_q);
      e2_d = KV * W2'(b2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      dir4_q <= dir3_q;
      e0_q   <= b0_q;
      e1_q   <= e1_d;
      e2_q   <= e2_d;
    end
  end

  // stage 5: offset, truncate, saturate into the output register
  logic signed [W2-1:0] u_off, v_off;
  logic [PixW-1:0]      first_b, u_b, v_b, g_b, r_b;
  pix_out_t             out_d, out_q;

  assign u_off = e1_q + OffUv;
  assign v_off = e2_q + OffUv;

  byc_clamp #(.Width(W1), .Shift(F)) u_clamp_first (
    .value_i(e0_q),
    .byte_o (first_b)
  );

  byc_clamp #(.Width(W2), .Shift(2 * F)) u_clamp_u (
    .value_i(u_off),
    .byte_o (u_b)
  );

  byc_clamp #(.Width(W2), .Shift(2 * F)) u_clamp_v (
    .value_i(v_off),
    .byte_o (v_b)
  );

  byc_clamp #(.Width(W1), .Shift(F)) u_clamp_g (
    .value_i(e1_q[W1-1:0]),
    .byte_o (g_b)
  );

  byc_clamp #(.Width(W1), .Shift(F)) u_clamp_r (
    .value_i(e2_q[W1-1:0]),
    .byte_o (r_b)
  );

  always_comb begin
    out_d.out_first  = first_b;
    out_d.out_second = (dir4_q == DirYuvToBgr) ? g_b : u_b;
    out_d.out_third  = (dir4_q == DirYuvToBgr) ? r_b : v_b;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[4]) begin
      out_q <= out_d;
    end
  end

  assign out_pixel_o = out_q;

endmodule
